>>> design/ssplt_pkg.sv
// shared types and constants for the substring match splitter
// no dependencies; imported by every module in the design folder
package ssplt_pkg;

  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned PLEN_W      = 4;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [POS_W-1:0] POS_SAT = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION      = 2'd2;

  typedef enum logic [1:0] {
    OP_FIND_FIRST = 2'd0,
    OP_LIST_ALL   = 2'd1,
    OP_SPLIT      = 2'd2,
    OP_END_ONLY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_MATCH = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0] pattern;
    logic [PLEN_W-1:0]        length;
    op_e                      op;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] length;
    logic             last;
  } result_t;

  // up to two results per byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> design/ssplt_scan.sv
// byte input register, sliding window compare and per-string state
// depends on ssplt_pkg; feeds ssplt_outq with up to two results per byte
module ssplt_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssplt_pkg::cfg_t cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_string_i,
  input  logic            space_i,
  output ssplt_pkg::push_t push_o
);
  import ssplt_pkg::*;

  logic                     valid_q, valid_d;
  logic [7:0]               byte_q;
  logic                     eos_q;
  logic                     go;

  logic [8*MAX_PATTERN-1:0] window_q, window_d;
  logic [POS_W-1:0]         count_q, count_d;
  logic [3:0]               since_q, since_d;
  logic [POS_W-1:0]         fstart_q, fstart_d;
  logic                     found_q, found_d;

  logic [PLEN_W-1:0]        plen;
  logic [2:0]               plen_m1;
  logic [MAX_PATTERN-1:0]   match_k;
  logic [3:0]               since_inc;
  logic                     hit;
  logic [POS_W-1:0]         end_pos, start_pos;
  logic [POS_W:0]           gap, tail_gap;
  logic                     a_v, b_v, c_v;
  result_t                  a_r, b_r, c_r;

  assign go         = valid_q & space_i;
  assign in_ready_o = ~valid_q | go;
  assign valid_d    = (in_valid_i & in_ready_o) | (valid_q & ~go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_string_i;
    end
  end

  // clamp pattern length to 1..MAX_PATTERN
  always_comb begin
    plen = cfg_i.length;
    if (plen == '0) plen = PLEN_W'(1);
    else if (plen > PLEN_W'(MAX_PATTERN)) plen = PLEN_W'(MAX_PATTERN);
    plen_m1 = 3'(plen - PLEN_W'(1));
  end

  assign window_d  = {window_q[8*MAX_PATTERN-9:0], byte_q};
  assign since_inc = (since_q == 4'hF) ? since_q : since_q + 4'd1;

  // one compare per candidate length, newest byte last in the pattern
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      match_k[k] = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (i <= k) begin
          if (window_d[8*(k-i) +: 8] != cfg_i.pattern[8*i +: 8]) match_k[k] = 1'b0;
        end
      end
    end
  end

  assign hit       = ({1'b0, since_inc} >= {1'b0, plen}) && match_k[plen_m1];
  assign end_pos   = (count_q == POS_SAT) ? POS_SAT : count_q + POS_W'(1);
  assign start_pos = (count_q == POS_SAT) ? POS_SAT : count_q - POS_W'(plen_m1);
  assign gap       = {1'b0, start_pos} - {1'b0, fstart_q};
  assign tail_gap  = {1'b0, end_pos} - {1'b0, fstart_q};

  always_comb begin
    found_d = found_q | (hit && cfg_i.op == OP_FIND_FIRST);

    a_v = 1'b0;
    a_r = '{kind: KIND_MATCH, position: start_pos, length: '0, last: 1'b0};
    unique case (cfg_i.op)
      OP_FIND_FIRST: begin
        a_v      = hit && !found_q;
        a_r.last = 1'b1;
      end
      OP_LIST_ALL: begin
        a_v = hit;
      end
      OP_SPLIT: begin
        a_v = hit && !gap[POS_W] && (gap[POS_W-1:0] != '0);
        a_r = '{kind: KIND_FIELD, position: fstart_q, length: gap[POS_W-1:0], last: 1'b0};
      end
      default: begin
        a_v = 1'b0;
      end
    endcase

    // trailing field; after a hit the field start already equals the end
    b_v = eos_q && (cfg_i.op == OP_SPLIT) && !hit && !tail_gap[POS_W]
          && (tail_gap[POS_W-1:0] != '0);
    b_r = '{kind: KIND_FIELD, position: fstart_q, length: tail_gap[POS_W-1:0], last: 1'b0};

    c_v = eos_q && !((cfg_i.op == OP_FIND_FIRST) && found_d);
    c_r = '{kind: KIND_END, position: '0, length: '0, last: 1'b1};

    push_o.r0    = c_r;
    push_o.r1    = c_r;
    push_o.count = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    if (a_v) begin
      push_o.r0 = a_r;
      push_o.r1 = b_v ? b_r : c_r;
    end else if (b_v) begin
      push_o.r0 = b_r;
    end
    if (!go) push_o.count = 2'd0;
  end

  always_comb begin
    count_d  = count_q;
    since_d  = since_q;
    fstart_d = fstart_q;
    if (go) begin
      count_d  = end_pos;
      since_d  = hit ? 4'd0 : since_inc;
      if (hit && cfg_i.op == OP_SPLIT) fstart_d = end_pos;
      if (eos_q) begin
        count_d  = '0;
        since_d  = '0;
        fstart_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
      since_q  <= '0;
      fstart_q <= '0;
      found_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      since_q  <= since_d;
      fstart_q <= fstart_d;
      if (go) begin
        window_q <= eos_q ? '0 : window_d;
        found_q  <= eos_q ? 1'b0 : found_d;
      end
    end
  end

  // never more than two results per byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o.count != 2'd3)
    else $error("more than two results for one byte");

  // the last byte of a string leaves cleared state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && eos_q |=> count_q == '0 && fstart_q == '0 && !found_q)
    else $error("state not cleared after final byte");

  // find-first reports at most one match per string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && found_q && !eos_q && cfg_i.op == OP_FIND_FIRST |-> push_o.count == 2'd0)
    else $error("second find-first result in one string");

endmodule

>>> design/ssplt_outq.sv
// four-entry result queue, up to two writes and one read per cycle
// depends on ssplt_pkg; drives the result channel of the top level
module ssplt_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssplt_pkg::push_t  push_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssplt_pkg::result_t head_o
);
  import ssplt_pkg::*;

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o & out_ready_i;
  assign space_o     = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign head_o      = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
  assign cnt_d    = cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> space_o)
    else $error("results pushed without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(cnt_q))
    else $error("queue pointers disagree with fill count");

endmodule

>>> design/substring_match_splitter_core.sv
// top level of the substring match splitter: configuration registers and wiring
// depends on ssplt_pkg, ssplt_scan and ssplt_outq
//
// usage
//   input channel: one string byte per beat (data_byte_i, end_of_string_i on
//   the final byte), valid/ready. a beat is registered, then compared against
//   the pattern and its results written to a result queue once it has room.
//   result channel: kind_o, position_o, length_o, last_o, valid/ready; a byte
//   causes zero, one or two result beats; one beat leaves per cycle when ready.
//   configuration channel: cfg_index_i selects pattern bytes, pattern length
//   or operation; always ready; the user must write it only while no string
//   is in flight, which the block itself does not enforce. a result passes
//   through the input byte register and then a result queue entry.
//   throughput: one byte per cycle; the result queue (four entries) is the
//   limit, the input stalls while fewer than two entries are free.
//   receiver stall: results wait in the queue, then the input stage holds its
//   byte and ready drops until room returns.
//   reset: pattern zero, length one, find-first, string state cleared,
//   queue empty; state is cleared again after every final byte
module substring_match_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] position_o,
  output logic [31:0] length_o,
  output logic        last_o
);
  import ssplt_pkg::*;

  cfg_t    cfg_q;
  push_t   push;
  logic    space;
  result_t head;

  // register writes are always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= '0;
      cfg_q.length  <= PLEN_W'(1);
      cfg_q.op      <= OP_FIND_FIRST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_BYTES:  cfg_q.pattern <= cfg_data_i;
        REG_PATTERN_LENGTH: cfg_q.length  <= cfg_data_i[PLEN_W-1:0];
        REG_OPERATION:      cfg_q.op      <= op_e'(cfg_data_i[1:0]);
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // window compare and per-string bookkeeping
  ssplt_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .space_i        (space),
    .push_o         (push)
  );

  // results queue up here, one beat out per cycle while the receiver is ready
  ssplt_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign kind_o     = head.kind;
  assign position_o = head.position;
  assign length_o   = head.length;
  assign last_o     = head.last;

endmodule
